// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define RPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define RPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/rpc_pkg.sv -----
// ----------------------------------------------------------------------------
// rpc_pkg
// types and constants shared by the radius point culler
// ----------------------------------------------------------------------------
package rpc_pkg;

  localparam int MAX_KEPT  = 1024;
  localparam int COORD_W   = 16;
  localparam int ADDR_W    = $clog2(MAX_KEPT);
  localparam int COUNT_W   = 11;
  localparam int RADIUS_W  = 16;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int R2_W      = 2 * RADIUS_W;
  localparam int ENTRY_W   = 3 * COORD_W;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(307);

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      first_point;
  } point_t;

  typedef struct packed {
    logic                      keep;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic [COUNT_W-1:0]        kept_total;
    logic                      list_full;
  } result_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } coord_t;

  typedef struct packed {
    logic pending;
    logic hit_valid;
    logic hit;
  } dist_stat_t;

endpackage

// ----- src/radius_point_culler.sv -----
// ----------------------------------------------------------------------------
// radius_point_culler
// greedy radius thinning of a stream of signed q8.8 3-d points
// ----------------------------------------------------------------------------
// One point is worked on at a time. A point that starts a set clears the
// list and goes straight to the result; any other point reads every stored
// point from the point memory, one entry per cycle, through a two-stage
// distance pipe; at most 1024 points are kept. A radius write lands in
// cull_radius, from which the squared radius r2 is registered. The result
// word sits in an output register.
// ----------------------------------------------------------------------------
module radius_point_culler import rpc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                point_valid,
  output logic                point_ready,
  input  point_t              point,
  output logic                result_valid,
  input  logic                result_ready,
  output result_t             result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [RADIUS_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DRAIN,
    FINISH
  } state_t;

  state_t               state;
  point_t               cur;
  logic [COUNT_W-1:0]   idx;
  logic [COUNT_W-1:0]   count;
  logic                 reject;
  logic                 rd_valid;
  logic [RADIUS_W-1:0]  cull_radius;
  logic [R2_W-1:0]      r2;

  logic                 rd_en;
  logic [ENTRY_W-1:0]   rd_data;
  logic                 wr_en;
  logic [ENTRY_W-1:0]   wr_data;
  coord_t               probe;
  dist_stat_t           dstat;
  logic                 out_free;
  logic                 keep_now;
  logic                 has_room;
  logic                 store;
  logic [COUNT_W-1:0]   count_next;

  assign point_ready = (state == IDLE);
  assign cfg_ready   = 1'b1;

  assign probe.x = cur.point_x;
  assign probe.y = cur.point_y;
  assign probe.z = cur.point_z;
  assign wr_data = probe;

  assign rd_en      = (state == SCAN) && (idx != count);
  assign out_free   = !result_valid || result_ready;
  assign keep_now   = !reject;
  assign has_room   = count != COUNT_W'(MAX_KEPT);
  assign store      = keep_now && has_room;
  assign wr_en      = (state == FINISH) && out_free && store;
  assign count_next = count + COUNT_W'(store);

  rpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_KEPT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  rpc_dist u_dist (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (rd_valid),
    .probe       (probe),
    .entry       (coord_t'(rd_data)),
    .r2          (r2),
    .stat        (dstat)
  );

  always_ff @(posedge clk) begin
    r2 <= R2_W'(cull_radius) * R2_W'(cull_radius);
    if (rst) begin
      state        <= IDLE;
      count        <= '0;
      idx          <= '0;
      reject       <= 1'b0;
      rd_valid     <= 1'b0;
      result_valid <= 1'b0;
      cull_radius  <= RADIUS_RESET;
    end else begin
      rd_valid <= rd_en;
      if (cfg_valid) begin
        cull_radius <= cfg_data;
      end
      if (dstat.hit_valid && dstat.hit) begin
        reject <= 1'b1;
      end
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (point_valid) begin
            cur    <= point;
            idx    <= '0;
            reject <= 1'b0;
            if (point.first_point) begin
              count <= '0;
              state <= FINISH;
            end else if (count == '0) begin
              state <= FINISH;
            end else begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (idx == count) begin
            state <= DRAIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        DRAIN: begin
          // wait until the last entry has left the distance pipe
          if (!rd_valid && !dstat.pending) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (out_free) begin
            result.keep       <= keep_now;
            result.out_x      <= cur.point_x;
            result.out_y      <= cur.point_y;
            result.out_z      <= cur.point_z;
            result.kept_total <= count_next;
            result.list_full  <= keep_now && !has_room;
            result_valid      <= 1'b1;
            count             <= count_next;
            state             <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/rpc_ram.sv -----
// ----------------------------------------------------------------------------
// rpc_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/rpc_dist.sv -----
// ----------------------------------------------------------------------------
// rpc_dist
// two-stage squared distance test of the current point against one entry
// ----------------------------------------------------------------------------
module rpc_dist import rpc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             entry_valid,
  input  coord_t           probe,
  input  coord_t           entry,
  input  logic [R2_W-1:0]  r2,
  output dist_stat_t       stat
);

  logic signed [COORD_W:0]     dx;
  logic signed [COORD_W:0]     dy;
  logic signed [COORD_W:0]     dz;
  logic signed [2*COORD_W+1:0] px;
  logic signed [2*COORD_W+1:0] py;
  logic signed [2*COORD_W+1:0] pz;
  logic [SQ_W-1:0]             sq_x;
  logic [SQ_W-1:0]             sq_y;
  logic [SQ_W-1:0]             sq_z;
  logic                        sq_valid;
  logic [SQ_W+1:0]             sum;
  logic                        hit_valid;
  logic                        hit;

  assign dx = {probe.x[COORD_W-1], probe.x} - {entry.x[COORD_W-1], entry.x};
  assign dy = {probe.y[COORD_W-1], probe.y} - {entry.y[COORD_W-1], entry.y};
  assign dz = {probe.z[COORD_W-1], probe.z} - {entry.z[COORD_W-1], entry.z};
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  // squares of 17-bit differences fit in 32 bits, so the sum never saturates
  assign sum = {2'b00, sq_x} + {2'b00, sq_y} + {2'b00, sq_z};

  always_ff @(posedge clk) begin
    sq_x <= px[SQ_W-1:0];
    sq_y <= py[SQ_W-1:0];
    sq_z <= pz[SQ_W-1:0];
    hit  <= sum < {2'b00, r2};
    if (rst) begin
      sq_valid  <= 1'b0;
      hit_valid <= 1'b0;
    end else begin
      sq_valid  <= entry_valid;
      hit_valid <= sq_valid;
    end
  end

  assign stat.pending   = sq_valid | hit_valid;
  assign stat.hit_valid = hit_valid;
  assign stat.hit       = hit;

endmodule

// ----- src/rpc_checker.sv -----
// ----------------------------------------------------------------------------
// rpc_checker
// port-level checks for the radius point culler, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpc_checker import rpc_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    point_valid,
  input logic    point_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  `RPC_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result), "result word changed while stalled")
  `RPC_ASSERT(a_one_at_a_time, point_valid && point_ready |=> !point_ready, "second point taken while busy")
  `RPC_ASSERT(a_total_range, result_valid |-> result.kept_total <= COUNT_W'(MAX_KEPT), "kept total beyond list size")
  `RPC_ASSERT(a_full_kept, result_valid && result.list_full |-> result.keep && result.kept_total == COUNT_W'(MAX_KEPT), "full flag without full list")
  `RPC_ASSERT_ALWAYS(a_reset_clear, rst |=> !result_valid, "result valid after reset")

endmodule

bind radius_point_culler rpc_checker u_rpc_checker (.*);
